/* hdl/scbc_pkg.sv */
// ----------------------------------------------------------------------------
// scbc_pkg
// Shared types and constants for the size class block cache.
// ----------------------------------------------------------------------------
package scbc_pkg;

  localparam int DATA_W     = 32;  // width of sizes, addresses on the ports
  localparam int HDR_W      = 8;   // width of header_size
  localparam int CFG_ADDR_W = 3;   // two 32-bit registers at 0x0 and 0x4

  localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_REGISTER = 2'd2,
    OP_DRAIN    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_BACKING    = 3'd1,
    ST_FORWARD    = 3'd2,
    ST_REGISTERED = 3'd3,
    ST_CACHED     = 3'd4,
    ST_RELEASE    = 3'd5,
    ST_DRAINED    = 3'd6,
    ST_EMPTY      = 3'd7
  } status_t;

  typedef enum logic {
    REG_ACTIVE = 1'b0,
    REG_HEADER = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FRD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // divider status seen by the controller
  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] quotient;
  } div_stat_t;

endpackage

/* hdl/scbc_if.sv */
// ----------------------------------------------------------------------------
// scbc_in_if / scbc_out_if
// Valid/ready channels carrying requests into and results out of the cache.
// ----------------------------------------------------------------------------
interface scbc_in_if;
  logic                               valid;
  logic                               ready;
  scbc_pkg::op_t                      op;
  logic signed [scbc_pkg::DATA_W-1:0] req_size;
  logic [scbc_pkg::DATA_W-1:0]        address;
  logic [scbc_pkg::DATA_W-1:0]        stored_size;
  logic                               magic_ok;

  modport source (output valid, op, req_size, address, stored_size, magic_ok,
                  input ready);
  modport sink   (input valid, op, req_size, address, stored_size, magic_ok,
                  output ready);
endinterface

interface scbc_out_if;
  logic                               valid;
  logic                               ready;
  scbc_pkg::status_t                  status;
  logic [scbc_pkg::DATA_W-1:0]        result_address;
  logic [scbc_pkg::DATA_W-1:0]        rounded_size;
  logic signed [scbc_pkg::DATA_W-1:0] live_blocks;
  logic signed [scbc_pkg::DATA_W-1:0] live_bytes;

  modport source (output valid, status, result_address, rounded_size,
                  live_blocks, live_bytes, input ready);
  modport sink   (input valid, status, result_address, rounded_size,
                  live_blocks, live_bytes, output ready);
endinterface

/* hdl/scbc_ram.sv */
// ----------------------------------------------------------------------------
// scbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/scbc_div.sv */
// ----------------------------------------------------------------------------
// scbc_div
// Divide by a constant: shift and mask for a power of two, else a restoring
// divider that retires four quotient bits per cycle.
// ----------------------------------------------------------------------------
module scbc_div #(
  parameter int DIVISOR = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scbc_pkg::DATA_W-1:0]   dividend,
  output scbc_pkg::div_stat_t           stat,
  output logic [$clog2(DIVISOR)-1:0]    remainder
);

  localparam int  DW      = scbc_pkg::DATA_W;
  localparam int  REM_W   = $clog2(DIVISOR);
  localparam bit  IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
  localparam int  STEPS   = 4;
  localparam int  ITER    = DW / STEPS;
  localparam int  CNT_W   = $clog2(ITER);
  localparam logic [REM_W:0]   DIV_K   = (REM_W + 1)'(DIVISOR);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ITER - 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [REM_W-1:0] rem_r;

  logic [DW-1:0]    step_quo;
  logic [REM_W-1:0] step_rem;
  logic [REM_W:0]   part;

  // quo_r shifts dividend bits out at the top and quotient bits in below
  always_comb begin
    step_quo = quo_r;
    step_rem = rem_r;
    part     = '0;
    for (int k = 0; k < STEPS; k++) begin
      part     = {step_rem, step_quo[DW-1]};
      step_quo = {step_quo[DW-2:0], 1'b0};
      if (part >= DIV_K) begin
        part        = part - DIV_K;
        step_quo[0] = 1'b1;
      end
      step_rem = part[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !IS_POW2;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_END) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (IS_POW2) begin
        quo_r <= dividend >> REM_W;
        rem_r <= dividend[REM_W-1:0];
      end else begin
        quo_r <= dividend;
        rem_r <= '0;
      end
    end else if (busy_r) begin
      quo_r <= step_quo;
      rem_r <= step_rem;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.quotient = quo_r;
  assign remainder     = rem_r;

endmodule

/* hdl/size_class_block_cache_core.sv */
// ----------------------------------------------------------------------------
// size_class_block_cache_core
// Recycle cache for memory blocks kept in per-size-class stacks, with live
// block and byte accounting.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               carries
//  --------  ---  ----------------------  -------------------------------------
//  in_ch     in   valid/ready             op, req_size, address, stored_size,
//                                         magic_ok
//  out_ch    out  valid/ready             status, result_address, rounded_size,
//                                         live_blocks, live_bytes
//  cfg_*     in   APB write/read, pready  active (0x0), header_size (0x4)
//
//  One request at a time. From accept to result register a request goes
//  through accept, class decode, fill read and stack read/modify/write;
//  when GRANULE is not a power of two the constant divider runs before
//  the class decode. The fill RAM and stack RAM reads are the serial steps.
//  The result register decouples out_ch: a new request is taken while a
//  result waits; the write-back step holds only while that register is full.
//  Reset clears the fill valid bits and counters; no clearing pass.
//
module size_class_block_cache_core #(
  parameter int GRANULE     = 16,
  parameter int MAX_CACHED  = 256,
  parameter int STACK_DEPTH = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  scbc_in_if.sink                           in_ch,
  scbc_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [scbc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [scbc_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [scbc_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DW          = scbc_pkg::DATA_W;
  localparam int HW          = scbc_pkg::HDR_W;
  localparam int NUM_CLASSES = MAX_CACHED / GRANULE;
  // at least two fill entries so the class index has a bit
  localparam int NUM_CL_MEM  = (NUM_CLASSES > 1) ? NUM_CLASSES : 2;
  localparam int CLS_W       = $clog2(NUM_CL_MEM);
  localparam int CLS_ENTRIES = 2 ** CLS_W;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int REM_W       = $clog2(GRANULE);
  localparam int STK_AW      = CLS_W + IDX_W;

  localparam logic [DW:0]       NUM_CL_K = (DW + 1)'(NUM_CLASSES);
  localparam logic [DW:0]       GRAN_K   = (DW + 1)'(GRANULE);
  localparam logic [FILL_W-1:0] FULL_K   = FILL_W'(STACK_DEPTH);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic          active_r;
  logic [HW-1:0] hdr_r;
  logic          cfg_wr;
  scbc_pkg::reg_idx_t cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = scbc_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      hdr_r    <= scbc_pkg::HDR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        scbc_pkg::REG_ACTIVE: active_r <= cfg_pwdata[0];
        scbc_pkg::REG_HEADER: hdr_r    <= cfg_pwdata[HW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      scbc_pkg::REG_ACTIVE: cfg_prdata = DW'(active_r);
      scbc_pkg::REG_HEADER: cfg_prdata = DW'(hdr_r);
    endcase
  end

  // --------------------------------------------------------------------------
  // request capture
  // --------------------------------------------------------------------------
  scbc_pkg::state_t state_r, state_nxt;

  scbc_pkg::op_t  op_r;
  logic [DW-1:0]  req_r;
  logic [DW-1:0]  addr_r;
  logic [DW-1:0]  ssz_r;
  logic           magic_r;
  logic [DW-1:0]  total_r;

  logic           in_fire;
  logic [DW-1:0]  req_u;
  logic [DW-1:0]  total_in;

  assign in_ch.ready = (state_r == scbc_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign req_u       = in_ch.req_size;
  // header plus request; wraps only for negative sizes, which are forwarded
  assign total_in    = req_u + DW'(hdr_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.op;
      req_r   <= req_u;
      addr_r  <= in_ch.address;
      ssz_r   <= in_ch.stored_size;
      magic_r <= in_ch.magic_ok;
      total_r <= total_in;
    end
  end

  // --------------------------------------------------------------------------
  // size to class: alloc divides the padded total, free the stored size
  // --------------------------------------------------------------------------
  scbc_pkg::div_stat_t div_stat;
  logic [REM_W-1:0]    div_rem;
  logic [DW-1:0]       div_dividend;

  assign div_dividend = (in_ch.op == scbc_pkg::OP_ALLOC) ? total_in : in_ch.stored_size;

  scbc_div #(
    .DIVISOR (GRANULE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .dividend  (div_dividend),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  logic            rem_nz;
  logic [DW:0]     q_ceil;     // ceil(total / GRANULE)
  logic [DW:0]     q_floor;
  logic [DW:0]     q_ceil_m1;
  logic [DW:0]     q_floor_m1;
  logic [DW:0]     rounded;
  logic            alloc_ok;
  logic            free_ok;

  assign rem_nz     = (div_rem != '0);
  assign q_floor    = {1'b0, div_stat.quotient};
  assign q_ceil     = q_floor + (DW + 1)'(rem_nz);
  assign q_ceil_m1  = q_ceil - 1'b1;
  assign q_floor_m1 = q_floor - 1'b1;
  assign rounded    = {1'b0, total_r} + (rem_nz ? GRAN_K - (DW + 1)'(div_rem) : '0);
  assign alloc_ok   = (q_ceil != '0) && (q_ceil <= NUM_CL_K);
  // cacheable free: non-zero multiple of GRANULE up to MAX_CACHED
  assign free_ok    = !rem_nz && (q_floor != '0) && (q_floor <= NUM_CL_K);

  // fill valid bits: set means the class stack holds at least one block
  logic [CLS_ENTRIES-1:0] nempty_r;
  logic                   drain_any;
  logic [CLS_W-1:0]       drain_cls;

  // lowest non-empty class
  always_comb begin
    drain_any = 1'b0;
    drain_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (nempty_r[i]) begin
        drain_any = 1'b1;
        drain_cls = CLS_W'(i);
      end
    end
  end

  logic [CLS_W-1:0] cls_sel;
  logic             ok_sel;

  always_comb begin
    case (op_r)
      scbc_pkg::OP_ALLOC: begin
        cls_sel = q_ceil_m1[CLS_W-1:0];
        ok_sel  = alloc_ok;
      end
      scbc_pkg::OP_FREE: begin
        cls_sel = q_floor_m1[CLS_W-1:0];
        ok_sel  = free_ok;
      end
      scbc_pkg::OP_REGISTER: begin
        cls_sel = '0;
        ok_sel  = 1'b0;
      end
      scbc_pkg::OP_DRAIN: begin
        cls_sel = drain_cls;
        ok_sel  = drain_any;
      end
    endcase
  end

  logic [CLS_W-1:0] cls_r;
  logic             cls_ok_r;
  logic             div_done;

  assign div_done = (state_r == scbc_pkg::S_DIV) && !div_stat.busy;

  always_ff @(posedge clk) begin
    if (div_done) begin
      cls_r    <= cls_sel;
      cls_ok_r <= ok_sel;
    end
  end

  // --------------------------------------------------------------------------
  // fill RAM and stack RAM
  // --------------------------------------------------------------------------
  logic              fill_we;
  logic [FILL_W-1:0] fill_wdata;
  logic [FILL_W-1:0] fill_rdata;
  logic [FILL_W-1:0] fill_cur;
  logic [FILL_W-1:0] fill_cur_m1;
  logic [FILL_W-1:0] fill_r;

  scbc_ram #(
    .WIDTH (FILL_W),
    .DEPTH (CLS_ENTRIES)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (cls_r),
    .wdata (fill_wdata),
    .re    (div_done),
    .raddr (cls_sel),
    .rdata (fill_rdata)
  );

  // entry content is meaningful only while its valid bit is set
  assign fill_cur    = nempty_r[cls_r] ? fill_rdata : '0;
  assign fill_cur_m1 = fill_cur - 1'b1;

  logic               stk_we;
  logic [ADDR_BITS-1:0] stk_wdata;
  logic [ADDR_BITS-1:0] stk_rdata;
  logic               stk_re;

  assign stk_re = (state_r == scbc_pkg::S_FRD);

  scbc_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (2 ** STK_AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr ({cls_r, fill_r[IDX_W-1:0]}),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr ({cls_r, fill_cur_m1[IDX_W-1:0]}),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (stk_re) begin
      fill_r <= fill_cur;
    end
  end

  // --------------------------------------------------------------------------
  // write-back and result
  // --------------------------------------------------------------------------
  logic [DW-1:0]        block_count_r;
  logic [DW-1:0]        byte_count_r;
  logic                 out_valid_r;
  scbc_pkg::status_t    out_status_r;
  logic [DW-1:0]        out_addr_r;
  logic [DW-1:0]        out_rsz_r;

  logic                 fin_go;
  scbc_pkg::status_t    res_status;
  logic [DW-1:0]        res_addr;
  logic [DW-1:0]        res_rsz;
  logic [DW-1:0]        blocks_nxt;
  logic [DW-1:0]        bytes_nxt;
  logic                 fill_upd;
  logic                 push;
  logic [ADDR_BITS-1:0] hdr_ab;
  logic [ADDR_BITS-1:0] blk_free;

  assign fin_go   = (state_r == scbc_pkg::S_FIN) && (!out_valid_r || out_ch.ready);
  assign hdr_ab   = ADDR_BITS'(hdr_r);
  assign blk_free = ADDR_BITS'(addr_r) - hdr_ab;

  always_comb begin
    res_status = scbc_pkg::ST_FORWARD;
    res_addr   = '0;
    res_rsz    = '0;
    blocks_nxt = block_count_r;
    bytes_nxt  = byte_count_r;
    fill_upd   = 1'b0;
    push       = 1'b0;
    fill_wdata = fill_r;
    case (op_r)
      scbc_pkg::OP_ALLOC: begin
        // inactive or negative size: forward
        if (active_r && !req_r[DW-1]) begin
          res_rsz = rounded[DW-1:0];
          if (cls_ok_r && (fill_r != '0)) begin
            res_status = scbc_pkg::ST_HIT;
            fill_upd   = 1'b1;
            fill_wdata = fill_r - 1'b1;
            blocks_nxt = block_count_r + 1'b1;
            bytes_nxt  = byte_count_r + rounded[DW-1:0];
            res_addr   = DW'(ADDR_BITS'(stk_rdata + hdr_ab));
          end else begin
            res_status = scbc_pkg::ST_BACKING;
          end
        end
      end
      scbc_pkg::OP_FREE: begin
        // inactive, null address or bad magic: forward
        if (active_r && (addr_r != '0) && magic_r) begin
          blocks_nxt = block_count_r - 1'b1;
          bytes_nxt  = byte_count_r - ssz_r;
          if (cls_ok_r && (fill_r < FULL_K)) begin
            res_status = scbc_pkg::ST_CACHED;
            push       = 1'b1;
            fill_upd   = 1'b1;
            fill_wdata = fill_r + 1'b1;
          end else begin
            res_status = scbc_pkg::ST_RELEASE;
            res_addr   = DW'(blk_free);
          end
        end
      end
      scbc_pkg::OP_REGISTER: begin
        res_status = scbc_pkg::ST_REGISTERED;
        blocks_nxt = block_count_r + 1'b1;
        bytes_nxt  = byte_count_r + ssz_r;
        res_addr   = DW'(ADDR_BITS'(ADDR_BITS'(addr_r) + hdr_ab));
        res_rsz    = ssz_r;
      end
      scbc_pkg::OP_DRAIN: begin
        if (cls_ok_r) begin
          res_status = scbc_pkg::ST_DRAINED;
          fill_upd   = 1'b1;
          fill_wdata = fill_r - 1'b1;
          res_addr   = DW'(stk_rdata);
        end else begin
          res_status = scbc_pkg::ST_EMPTY;
        end
      end
    endcase
  end

  assign fill_we   = fin_go && fill_upd;
  assign stk_we    = fin_go && push;
  assign stk_wdata = blk_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nempty_r      <= '0;
      block_count_r <= '0;
      byte_count_r  <= '0;
    end else if (fin_go) begin
      block_count_r <= blocks_nxt;
      byte_count_r  <= bytes_nxt;
      if (fill_upd) begin
        nempty_r[cls_r] <= (fill_wdata != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_rsz_r    <= res_rsz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.rounded_size   = out_rsz_r;
  assign out_ch.live_blocks    = block_count_r;
  assign out_ch.live_bytes     = byte_count_r;

  // --------------------------------------------------------------------------
  // sequencer; one request in flight, so RAM accesses never overlap
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scbc_pkg::S_IDLE: if (in_fire)  state_nxt = scbc_pkg::S_DIV;
      scbc_pkg::S_DIV:  if (div_done) state_nxt = scbc_pkg::S_FRD;
      scbc_pkg::S_FRD:                state_nxt = scbc_pkg::S_FIN;
      scbc_pkg::S_FIN:  if (fin_go)   state_nxt = scbc_pkg::S_IDLE;
      default:                        state_nxt = scbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scbc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a fill count never exceeds the stack depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (fill_wdata <= FULL_K))
    else $error("fill count above stack depth");

  // a drain picked by the valid bits must find a non-empty stack
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scbc_pkg::S_FIN && op_r == scbc_pkg::OP_DRAIN && cls_ok_r)
      |-> (fill_r != '0))
    else $error("drain of an empty class");

  // results are only produced by the write-back step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == scbc_pkg::S_FIN))
    else $error("result outside write-back");

  // a push only lands on a stack with room
  assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (fill_r < FULL_K && op_r == scbc_pkg::OP_FREE))
    else $error("push onto a full stack");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for size_class_block_cache_core. It drives alloc, free, register
// and drain requests through the valid/ready channels and programs the
// registers over APB. Each result is checked against a cycle-free predictor
// of the class stacks and the live counters. Random idling and stalling run
// on both sides, plus one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import scbc_pkg::*;

  // block geometry, passed down to the block
  localparam int GRANULE     = 16;
  localparam int MAX_CACHED  = 256;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_BITS   = 32;
  localparam int NUM_CLASSES = MAX_CACHED / GRANULE;

  localparam int HOLD_OFF_CYCLES = 300;     // long result-side stall
  localparam int QUIET_CYCLES    = 8;       // longer than one request takes here
  localparam int CYCLE_LIMIT     = 400000;

  // one predicted result
  typedef struct {
    status_t     status;
    logic [31:0] address;
    logic [31:0] size;
    logic [31:0] blocks;
    logic [31:0] bytes;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scbc_in_if  in_ch ();
  scbc_out_if out_ch ();

  // predictor state: class stacks, fill levels, counters, register shadows
  logic [31:0] class_stack [NUM_CLASSES][STACK_DEPTH];
  int unsigned class_fill [NUM_CLASSES];
  logic [31:0] live_block_cnt;
  logic [31:0] live_byte_cnt;
  logic        cfg_active;
  logic [7:0]  cfg_header;

  cache_result_t pending_results[$];   // results owed by the block, oldest first

  // blocks the client side currently owns: user address and stored size
  logic [31:0] held_addr[$];
  logic [31:0] held_size[$];

  bit          idle_on;
  int unsigned hold_offs_asked;
  int unsigned hold_offs_served;
  int unsigned error_count;
  int unsigned cycle_count;

  size_class_block_cache_core #(
    .GRANULE     (GRANULE),
    .MAX_CACHED  (MAX_CACHED),
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs or drops a result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor. Works out the result of one accepted request and updates the
  // shadow state. Address math wraps at 32 bits; counters wrap too.
  // --------------------------------------------------------------------------
  function automatic cache_result_t next_cache_result(op_t op, logic [31:0] req,
                                                      logic [31:0] addr,
                                                      logic [31:0] ssz,
                                                      logic magic);
    cache_result_t r;
    logic [63:0]   total;
    logic [63:0]   rounded;
    logic [31:0]   blk;
    int            cls;
    r.status  = ST_FORWARD;
    r.address = '0;
    r.size    = '0;
    case (op)
      OP_ALLOC: begin
        // negative sizes and inactive mode go back to the original allocator
        if (cfg_active && !req[31]) begin
          total     = 64'(req) + 64'(cfg_header);
          rounded   = (total + 64'(GRANULE - 1)) / GRANULE * GRANULE;
          r.status  = ST_BACKING;
          r.size    = rounded[31:0];
          // rounded size zero has no class and can never hit
          if (rounded != 0 && rounded <= MAX_CACHED) begin
            cls = int'(rounded / GRANULE) - 1;
            if (class_fill[cls] > 0) begin
              class_fill[cls] = class_fill[cls] - 1;
              blk             = class_stack[cls][class_fill[cls]];
              live_block_cnt  = live_block_cnt + 1;
              live_byte_cnt   = live_byte_cnt + rounded[31:0];
              r.status        = ST_HIT;
              r.address       = blk + 32'(cfg_header);
            end
          end
        end
      end
      OP_FREE: begin
        // null address and bad magic are forwarded untouched
        if (cfg_active && addr != 0 && magic) begin
          blk            = addr - 32'(cfg_header);
          live_block_cnt = live_block_cnt - 1;
          live_byte_cnt  = live_byte_cnt - ssz;
          r.status       = ST_RELEASE;
          r.address      = blk;
          // only whole-granule sizes within range are kept, and only if room
          if (ssz != 0 && ssz <= MAX_CACHED && ssz % GRANULE == 0) begin
            cls = int'(ssz / GRANULE) - 1;
            if (class_fill[cls] < STACK_DEPTH) begin
              class_stack[cls][class_fill[cls]] = blk;
              class_fill[cls] = class_fill[cls] + 1;
              r.status        = ST_CACHED;
              r.address       = '0;
            end
          end
        end
      end
      OP_REGISTER: begin
        // accounted even while inactive
        live_block_cnt = live_block_cnt + 1;
        live_byte_cnt  = live_byte_cnt + ssz;
        r.status       = ST_REGISTERED;
        r.address      = addr + 32'(cfg_header);
        r.size         = ssz;
      end
      default: begin
        // drain: lowest non-empty class gives up its top block
        r.status = ST_EMPTY;
        for (int c = 0; c < NUM_CLASSES && r.status == ST_EMPTY; c++) begin
          if (class_fill[c] > 0) begin
            class_fill[c] = class_fill[c] - 1;
            r.status      = ST_DRAINED;
            r.address     = class_stack[c][class_fill[c]];
          end
        end
      end
    endcase
    r.blocks = live_block_cnt;
    r.bytes  = live_byte_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Entered and left at a rising edge. Valid stays high between
  // back-to-back requests; a random gap may lower it first while idling is on.
  // --------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [31:0] req,
                              input logic [31:0] addr, input logic [31:0] ssz,
                              input logic magic, output cache_result_t res);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.req_size    <= req;
    in_ch.address     <= addr;
    in_ch.stored_size <= ssz;
    in_ch.magic_ok    <= magic;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted at this edge: predict in acceptance order
    res = next_cache_result(op, req, addr, ssz, magic);
    pending_results.push_back(res);
  endtask

  // Drop valid and wait for every owed result, then let the pipe settle.
  task automatic wait_until_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB: setup cycle, access cycle, then an idle cycle so that a following
  // transfer never re-drives psel in the same step.
  // --------------------------------------------------------------------------
  task automatic apb_transfer(input reg_idx_t idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input reg_idx_t idx);
    logic [31:0] got;
    logic [31:0] want;
    apb_transfer(idx, 1'b0, '0, got);
    want = (idx == REG_ACTIVE) ? {31'b0, cfg_active} : {24'b0, cfg_header};
    if (got !== want) begin
      $error("register %s: expected %h, got %h", idx.name(), want, got);
      error_count++;
    end
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(idx, 1'b1, value, unused);
    if (idx == REG_ACTIVE) cfg_active = value[0];
    else cfg_header = value[7:0];
    check_register(idx);
  endtask

  // Reconfigure only with the block idle.
  task automatic set_mode(input logic act, input logic [7:0] hdr);
    wait_until_quiet();
    write_register(REG_ACTIVE, {31'b0, act});
    write_register(REG_HEADER, {24'b0, hdr});
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Mostly a well-behaved client: allocs that miss are at times
  // backed and registered, owned blocks get freed with their stored size. The rest
  // is drains, stray registers and fully random noise.
  // --------------------------------------------------------------------------
  task automatic issue_random_request();
    cache_result_t res;
    int unsigned   pick;
    int unsigned   idx;
    logic [31:0]   req;
    logic [31:0]   ssz;
    pick = $urandom_range(0, 99);
    // keep the owned pool from growing without bound
    if (held_addr.size() > 48 && pick < 35) pick = 40;
    if (pick < 35) begin
      if ($urandom_range(0, 9) == 0) req = $urandom;
      else req = $urandom_range(0, 260);
      send_request(OP_ALLOC, req, $urandom, $urandom, 1'($urandom), res);
      if (res.status == ST_HIT) begin
        held_addr.push_back(res.address);
        held_size.push_back(res.size);
      end else if (res.status == ST_BACKING && $urandom_range(0, 1) == 1) begin
        // miss: back the block elsewhere and hand it to the cache
        send_request(OP_REGISTER, $urandom, $urandom & 32'hFFFF_FFF0, res.size,
                     1'($urandom), res);
        held_addr.push_back(res.address);
        held_size.push_back(res.size);
      end
    end else if (pick < 65 && held_addr.size() > 0) begin
      idx = $urandom_range(0, held_addr.size() - 1);
      send_request(OP_FREE, $urandom, held_addr[idx], held_size[idx],
                   $urandom_range(0, 19) != 0, res);
      held_addr.delete(idx);
      held_size.delete(idx);
    end else if (pick < 75) begin
      if ($urandom_range(0, 3) == 0) ssz = $urandom;
      else ssz = GRANULE * $urandom_range(1, NUM_CLASSES);
      send_request(OP_REGISTER, $urandom, $urandom, ssz, 1'($urandom), res);
      held_addr.push_back(res.address);
      held_size.push_back(ssz);
    end else if (pick < 82) begin
      send_request(OP_DRAIN, $urandom, $urandom, $urandom, 1'($urandom), res);
    end else begin
      send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                   1'($urandom), res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset values of both registers
  task automatic test_register_reset();
    check_register(REG_ACTIVE);
    check_register(REG_HEADER);
  endtask

  // inactive after reset: alloc/free forwarded, register still counted
  task automatic test_inactive_forwarding();
    cache_result_t res;
    send_request(OP_ALLOC, 32'd100, '0, '0, 1'b0, res);
    send_request(OP_FREE, '0, 32'h0000_1000, 32'd64, 1'b1, res);
    send_request(OP_REGISTER, '0, 32'h0000_4000, 32'd64, 1'b0, res);
    send_request(OP_DRAIN, '0, '0, '0, 1'b0, res);
  endtask

  // field extremes and the documented corner cases
  task automatic test_special_cases();
    cache_result_t res;
    set_mode(1'b1, 8'd16);
    send_request(OP_ALLOC, 32'h8000_0000, '0, '0, 1'b0, res);      // negative size
    send_request(OP_ALLOC, 32'h7FFF_FFFF, '0, '0, 1'b0, res);      // largest size
    send_request(OP_ALLOC, 32'd0, '0, '0, 1'b0, res);              // miss
    send_request(OP_FREE, '0, 32'h0, 32'd32, 1'b1, res);           // null address
    send_request(OP_FREE, '0, 32'h0000_2010, 32'd32, 1'b0, res);   // bad magic
    send_request(OP_FREE, '0, 32'h0000_2010, 32'd32, 1'b1, res);   // cached
    send_request(OP_ALLOC, 32'd16, '0, '0, 1'b0, res);             // hit
    send_request(OP_FREE, '0, 32'h0000_3010, 32'd0, 1'b1, res);    // size zero
    send_request(OP_FREE, '0, 32'h0000_3010, 32'd24, 1'b1, res);   // not granular
    send_request(OP_FREE, '0, 32'h0000_3010, 32'd272, 1'b1, res);  // too big
    send_request(OP_FREE, '0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1, res);
    send_request(OP_FREE, '0, 32'hFFFF_FFFF, 32'd256, 1'b1, res);  // top class
    send_request(OP_FREE, '0, 32'h0000_0008, 32'd16, 1'b1, res);   // block addr wraps
    send_request(OP_DRAIN, '0, '0, '0, 1'b0, res);                 // lowest class first
    send_request(OP_DRAIN, '0, '0, '0, 1'b0, res);
    send_request(OP_DRAIN, '0, '0, '0, 1'b0, res);                 // nothing cached
    send_request(OP_REGISTER, '0, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 1'b1, res);
    // no header: a zero-byte alloc rounds to zero and must miss
    set_mode(1'b1, 8'd0);
    send_request(OP_ALLOC, 32'd0, '0, '0, 1'b0, res);
    send_request(OP_FREE, '0, 32'h0000_0050, 32'd16, 1'b1, res);
    send_request(OP_ALLOC, 32'd1, '0, '0, 1'b0, res);
    // largest header
    set_mode(1'b1, 8'd255);
    send_request(OP_ALLOC, 32'h7FFF_FFFF, '0, '0, 1'b0, res);
    send_request(OP_ALLOC, 32'd1, '0, '0, 1'b0, res);
    send_request(OP_FREE, '0, 32'h0000_01FF, 32'd256, 1'b1, res);
    send_request(OP_ALLOC, 32'd1, '0, '0, 1'b0, res);
  endtask

  // overfill the 64-byte class: the extra free must be released
  task automatic test_stack_full();
    cache_result_t res;
    set_mode(1'b1, 8'd16);
    repeat (STACK_DEPTH + 1)
      send_request(OP_FREE, $urandom, $urandom | 32'h100, 32'd64, 1'b1, res);
    repeat (8) send_request(OP_ALLOC, 32'd48, $urandom, $urandom, 1'b0, res);
  endtask

  // sink holds off for a long time while requests keep coming
  task automatic test_backpressure();
    hold_offs_asked++;
    repeat (40) issue_random_request();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) issue_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Result side: long hold-off on request, random stall bursts, else ready.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_offs_served != hold_offs_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_served++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    cache_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d", out_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.result_address !== want.address) begin
          $error("result_address: expected %h, got %h", want.address,
                 out_ch.result_address);
          error_count++;
        end
        if (out_ch.rounded_size !== want.size) begin
          $error("rounded_size: expected %h, got %h", want.size, out_ch.rounded_size);
          error_count++;
        end
        if (out_ch.live_blocks !== want.blocks) begin
          $error("live_blocks: expected %h, got %h", want.blocks, out_ch.live_blocks);
          error_count++;
        end
        if (out_ch.live_bytes !== want.bytes) begin
          $error("live_bytes: expected %h, got %h", want.bytes, out_ch.live_bytes);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_ALLOC;
    in_ch.req_size    = '0;
    in_ch.address     = '0;
    in_ch.stored_size = '0;
    in_ch.magic_ok    = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    // predictor matches the block's reset state
    foreach (class_fill[c]) class_fill[c] = 0;
    live_block_cnt    = '0;
    live_byte_cnt     = '0;
    cfg_active        = 1'b0;
    cfg_header        = HDR_RESET;
    idle_on           = 1'b1;
    hold_offs_asked   = 0;
    hold_offs_served  = 0;
    error_count       = 0;
    cycle_count       = 0;

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_inactive_forwarding();
    test_special_cases();
    test_stack_full();
    test_backpressure();

    set_mode(1'b1, 8'd16);
    test_random_traffic(400);
    set_mode(1'b1, 8'd0);
    test_random_traffic(200);
    set_mode(1'b1, 8'd255);
    test_random_traffic(200);
    // inactive again: only register and drain change anything
    set_mode(1'b0, 8'($urandom));
    test_random_traffic(100);
    set_mode(1'b1, 8'($urandom));
    test_random_traffic(250);

    // closing stretch runs at full rate on both sides
    set_mode(1'b1, 8'd16);
    idle_on = 1'b0;
    test_random_traffic(200);

    wait_until_quiet();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
